// ----- src/grid_astar_path_search_assert.svh -----
// ============================================================================
// Grid A* path search assertion macros
// Shared wrappers for the concurrent checks of the path search block.
// ============================================================================
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// Check that is switched off while reset is high.
`define GASP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error(msg);

// Check that also looks at reset itself.
`define GASP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
   else $error(msg);

`endif

// ----- src/gasp_pkg.sv -----
// ============================================================================
// Grid A* path search package
// Grid sizes, field widths, move codes and the structs shared by the modules.
// ============================================================================
`timescale 1ns / 1ps

package gasp_pkg;

   // Grid geometry.
   localparam int GRID_ROWS = 33;
   localparam int GRID_COLS = 33;
   localparam int CELLS     = GRID_ROWS * GRID_COLS;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int TB_DEPTH  = CELLS + 1;
   localparam int TB_W      = $clog2(TB_DEPTH);

   // Field widths.
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int ROWBITS_W  = 33;
   localparam int COST_W     = 11;
   localparam int LEN_W      = 11;
   localparam int FRAC_BITS  = 24;
   localparam int EST_W      = 36;
   localparam int WORD_W     = 64;
   localparam int CNT_W      = 6;
   localparam int WORD_MOVES = 32;

   // Square root operand: squared distance shifted up by two fraction widths.
   localparam int D2_W   = 12;
   localparam int RAD_W  = D2_W + 2 * FRAC_BITS;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int ITER_W = $clog2(ROOT_W);

   // Item function codes.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // Move codes.
   localparam logic [1:0] MV_COL_DEC = 2'd0;
   localparam logic [1:0] MV_ROW_DEC = 2'd1;
   localparam logic [1:0] MV_COL_INC = 2'd2;
   localparam logic [1:0] MV_ROW_INC = 2'd3;

   // Neighbors are visited in this order.
   localparam logic [1:0] SCAN_ORDER [4] = '{MV_ROW_DEC, MV_ROW_INC, MV_COL_INC, MV_COL_DEC};

   // Per-cell flag codes: bit 1 discovered, bit 0 closed.
   localparam int         FLAG_DISC_BIT   = 1;
   localparam int         FLAG_CLOSED_BIT = 0;
   localparam logic [1:0] FLAGS_NONE      = 2'b00;
   localparam logic [1:0] FLAGS_OPEN      = 2'b10;
   localparam logic [1:0] FLAGS_CLOSED    = 2'b11;

   typedef logic [CELL_W-1:0] cell_idx_type;

   // Per-cell search data.
   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [EST_W-1:0]  est;
      logic [1:0]        dir;
   } cell_data_type;

   // Item handed from the top level to the search core.
   typedef struct packed {
      logic                 load;
      logic                 search;
      logic [ROW_W-1:0]     row_index;
      logic [ROWBITS_W-1:0] row_bits;
      logic [ROW_W-1:0]     start_row;
      logic [COL_W-1:0]     start_col;
      logic [ROW_W-1:0]     goal_row;
      logic [COL_W-1:0]     goal_col;
   } req_type;

   // Result word offered by the search core.
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [LEN_W-1:0]  path_length;
      logic [WORD_W-1:0] moves_word;
      logic [CNT_W-1:0]  moves_in_word;
      logic              last;
   } rsp_type;

   // Linear cell address of a row and column.
   function automatic cell_idx_type cell_index(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
      return cell_idx_type'(r * GRID_COLS + c);
   endfunction

endpackage

// ----- src/grid_astar_path_search.sv -----
// ============================================================================
// Grid A* path search
// A* search over a loadable 33 by 33 grid with a registered result port.
// ============================================================================
`timescale 1ns / 1ps
`include "grid_astar_path_search_assert.svh"

// A row load leaves the block ready for the next item. A search holds
// req_stall high until its last result word has moved into the output
// register: it starts with a pass that clears the cell flags, then each pop
// scans all 1089 cells through the cell memories, and each candidate neighbor
// goes through the shared one-bit-per-cycle square root unit. The trace back
// then walks from cell to parent, and the moves are packed into result words.
// A search that fails at once on its coordinates offers a single failure word.

module grid_astar_path_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [gasp_pkg::ROW_W-1:0]      req_row_index,
   input  logic [gasp_pkg::ROWBITS_W-1:0]  req_row_open_bits,
   input  logic [gasp_pkg::ROW_W-1:0]      req_start_row,
   input  logic [gasp_pkg::COL_W-1:0]      req_start_col,
   input  logic [gasp_pkg::ROW_W-1:0]      req_goal_row,
   input  logic [gasp_pkg::COL_W-1:0]      req_goal_col,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [gasp_pkg::LEN_W-1:0]      rsp_path_length,
   output logic [gasp_pkg::WORD_W-1:0]     rsp_moves_word,
   output logic [gasp_pkg::CNT_W-1:0]      rsp_moves_in_word,
   output logic                            rsp_last
);

   gasp_pkg::req_type              core_req;
   gasp_pkg::rsp_type              core_rsp;
   logic                           core_busy;
   logic                           core_take;
   logic                           req_xfer;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff;
   logic [gasp_pkg::LEN_W-1:0]     rsp_len_ff;
   logic [gasp_pkg::WORD_W-1:0]    rsp_word_ff;
   logic [gasp_pkg::CNT_W-1:0]     rsp_cnt_ff;
   logic                           rsp_last_ff;

   // Input transfer decode.
   assign req_stall = core_busy;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      core_req.load      = req_xfer && (req_func == gasp_pkg::FUNC_LOAD);
      core_req.search    = req_xfer && (req_func == gasp_pkg::FUNC_SEARCH);
      core_req.row_index = req_row_index;
      core_req.row_bits  = req_row_open_bits;
      core_req.start_row = req_start_row;
      core_req.start_col = req_start_col;
      core_req.goal_row  = req_goal_row;
      core_req.goal_col  = req_goal_col;
   end

   gasp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (core_req),
      .rsp_take (core_take),
      .rsp      (core_rsp),
      .busy     (core_busy)
   );

   // Output register: a word moves in when the register is empty or emptying.
   assign core_take = core_rsp.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_take) begin
         rsp_found_ff <= core_rsp.found;
         rsp_len_ff   <= core_rsp.path_length;
         rsp_word_ff  <= core_rsp.moves_word;
         rsp_cnt_ff   <= core_rsp.moves_in_word;
         rsp_last_ff  <= core_rsp.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_path_length   = rsp_len_ff;
   assign rsp_moves_word    = rsp_word_ff;
   assign rsp_moves_in_word = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   // Concurrent checks.
   `GASP_ASSERT(a_search_goes_busy, (req_xfer && req_func == gasp_pkg::FUNC_SEARCH) |=> req_stall, "search transfer did not make the block busy")
   `GASP_ASSERT(a_core_word_holds, (core_rsp.valid && !core_take) |=> core_rsp.valid, "core dropped a result word before its transfer")
   `GASP_ASSERT(a_word_count_ok, core_rsp.valid |-> (core_rsp.moves_in_word <= 6'd32 && (core_rsp.found || core_rsp.moves_in_word == 6'd0)), "bad move count in result word")
   `GASP_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "output register not empty after reset")

endmodule

// ----- src/gasp_isqrt.sv -----
// ============================================================================
// Iterative integer square root
// Produces floor(sqrt(d2 * 2^48)), one result bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module gasp_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gasp_pkg::D2_W-1:0]     d2,
   output logic                          done,
   output logic [gasp_pkg::ROOT_W-1:0]   root
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [gasp_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [gasp_pkg::RAD_W-1:0]     rad_ff, rad_in;
   logic [gasp_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [gasp_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [gasp_pkg::REM_W-1:0]     rem_sh;
   logic [gasp_pkg::REM_W-1:0]     trial;

   // One restoring step: bring down two radicand bits and try the next root bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[gasp_pkg::REM_W-3:0], rad_ff[gasp_pkg::RAD_W-1 -: 2]};
      trial   = gasp_pkg::REM_W'({root_ff, 2'b01});
      if (start) begin
         busy_in = 1'b1;
         iter_in = gasp_pkg::ITER_W'(gasp_pkg::ROOT_W - 1);
         rad_in  = {d2, {(2 * gasp_pkg::FRAC_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[gasp_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[gasp_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[gasp_pkg::ROOT_W-2:0], 1'b0};
         end
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff - gasp_pkg::ITER_W'(1);
         end
      end
   end

   // Control registers are reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- src/gasp_core.sv -----
// ============================================================================
// Grid A* search core
// Holds the grid and the per-cell search state and runs the search sequencer.
// ============================================================================
`timescale 1ns / 1ps

module gasp_core (
   input  logic              clock,
   input  logic              reset,
   input  gasp_pkg::req_type req,
   input  logic              rsp_take,
   output gasp_pkg::rsp_type rsp,
   output logic              busy
);

   // Sequencer states.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CLEAR = 5'd1;
   localparam logic [4:0] S_INIT  = 5'd2;
   localparam logic [4:0] S_SCAN  = 5'd3;
   localparam logic [4:0] S_SCANW = 5'd4;
   localparam logic [4:0] S_POP   = 5'd5;
   localparam logic [4:0] S_NB    = 5'd6;
   localparam logic [4:0] S_NBADR = 5'd7;
   localparam logic [4:0] S_NBCHK = 5'd8;
   localparam logic [4:0] S_SQRT  = 5'd9;
   localparam logic [4:0] S_NBUPD = 5'd10;
   localparam logic [4:0] S_TLOOP = 5'd11;
   localparam logic [4:0] S_TRD   = 5'd12;
   localparam logic [4:0] S_EWORD = 5'd13;
   localparam logic [4:0] S_ERD   = 5'd14;
   localparam logic [4:0] S_ERX   = 5'd15;
   localparam logic [4:0] S_EOUT  = 5'd16;
   localparam logic [4:0] S_FAIL  = 5'd17;

   logic [4:0]                     state_ff, state_in;
   logic [gasp_pkg::ROW_W-1:0]     sr_ff, sr_in, gr_ff, gr_in;
   logic [gasp_pkg::COL_W-1:0]     sc_ff, sc_in, gc_ff, gc_in;
   logic [gasp_pkg::CELL_W-1:0]    idx_ff, idx_in;
   logic [gasp_pkg::ROW_W-1:0]     scan_r_ff, scan_r_in, pr_ff, pr_in;
   logic [gasp_pkg::COL_W-1:0]     scan_c_ff, scan_c_in, pc_ff, pc_in;
   logic                           pv_ff, pv_in;
   logic                           best_found_ff, best_found_in;
   logic [gasp_pkg::EST_W-1:0]     best_est_ff, best_est_in;
   logic [gasp_pkg::COST_W-1:0]    best_cost_ff, best_cost_in;
   logic [gasp_pkg::ROW_W-1:0]     best_r_ff, best_r_in;
   logic [gasp_pkg::COL_W-1:0]     best_c_ff, best_c_in;
   logic [1:0]                     n_ff, n_in;
   logic [1:0]                     nb_dir_ff, nb_dir_in;
   logic [gasp_pkg::ROW_W-1:0]     nb_r_ff, nb_r_in;
   logic [gasp_pkg::COL_W-1:0]     nb_c_ff, nb_c_in;
   logic                           nb_ok_ff, nb_ok_in;
   logic [gasp_pkg::LEN_W-1:0]     t_len_ff, t_len_in;
   logic [gasp_pkg::TB_W-1:0]      k_ff, k_in;
   logic [gasp_pkg::ROW_W-1:0]     t_r_ff, t_r_in;
   logic [gasp_pkg::COL_W-1:0]     t_c_ff, t_c_in;
   logic [gasp_pkg::TB_W-1:0]      e_idx_ff, e_idx_in;
   logic [gasp_pkg::LEN_W-1:0]     total_ff, total_in;
   logic [gasp_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [gasp_pkg::CNT_W-1:0]     pos_ff, pos_in;
   logic [gasp_pkg::CNT_W-1:0]     wcnt_ff, wcnt_in;
   logic [gasp_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [gasp_pkg::GRID_ROWS-1:0] row_valid_ff;

   // Memories and their ports.
   logic [1:0]                     flag_mem [gasp_pkg::CELLS];
   gasp_pkg::cell_data_type        data_mem [gasp_pkg::CELLS];
   logic [gasp_pkg::GRID_COLS-1:0] open_mem [gasp_pkg::GRID_ROWS];
   logic [1:0]                     tb_mem   [gasp_pkg::TB_DEPTH];
   logic [1:0]                     flag_rd_ff;
   gasp_pkg::cell_data_type        data_rd_ff;
   logic [gasp_pkg::GRID_COLS-1:0] open_rd_ff;
   logic [1:0]                     tb_rd_ff;
   gasp_pkg::cell_idx_type         rd_addr;
   logic                           flag_we, data_we, tb_we;
   gasp_pkg::cell_idx_type         flag_wa, data_wa;
   logic [1:0]                     flag_wd, tb_wd;
   gasp_pkg::cell_data_type        data_wd;
   logic [gasp_pkg::TB_W-1:0]      tb_wa;
   logic                           row_load;

   // Shared square root unit.
   logic                           sq_start, sq_done;
   logic [gasp_pkg::D2_W-1:0]      sq_d2;
   logic [gasp_pkg::ROOT_W-1:0]    sq_root;

   // Helpers.
   gasp_pkg::cell_idx_type         nb_idx, start_idx;
   logic                           open_bit;
   logic [gasp_pkg::ROW_W-1:0]     dr;
   logic [gasp_pkg::COL_W-1:0]     dc;
   logic [gasp_pkg::COST_W-1:0]    g;
   logic [gasp_pkg::EST_W-1:0]     f;
   logic [gasp_pkg::COST_W:0]      len_full;
   logic                           par_ok;
   logic [gasp_pkg::ROW_W-1:0]     par_r;
   logic [gasp_pkg::COL_W-1:0]     par_c;

   gasp_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .d2    (sq_d2),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign nb_idx    = gasp_pkg::cell_index(nb_r_ff, nb_c_ff);
   assign start_idx = gasp_pkg::cell_index(sr_ff, sc_ff);
   assign open_bit  = row_valid_ff[nb_r_ff] & open_rd_ff[nb_c_ff];
   assign row_load  = req.load && (req.row_index < gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS));

   // Distance to the goal and the new estimate of the neighbor.
   assign dr       = (nb_r_ff > gr_ff) ? nb_r_ff - gr_ff : gr_ff - nb_r_ff;
   assign dc       = (nb_c_ff > gc_ff) ? nb_c_ff - gc_ff : gc_ff - nb_c_ff;
   assign sq_d2    = gasp_pkg::D2_W'(dr * dr) + gasp_pkg::D2_W'(dc * dc);
   assign g        = best_cost_ff + gasp_pkg::COST_W'(1);
   assign f        = gasp_pkg::EST_W'({g, {gasp_pkg::FRAC_BITS{1'b0}}})
                     + gasp_pkg::EST_W'(sq_root);
   assign len_full = {1'b0, best_cost_ff} + (gasp_pkg::COST_W + 1)'(1);

   // Parent of the traced cell: step back against its recorded move.
   always_comb begin
      par_r  = t_r_ff;
      par_c  = t_c_ff;
      par_ok = 1'b0;
      unique case (data_rd_ff.dir)
         gasp_pkg::MV_COL_DEC: begin
            par_ok = t_c_ff < gasp_pkg::COL_W'(gasp_pkg::GRID_COLS - 1);
            par_c  = t_c_ff + gasp_pkg::COL_W'(1);
         end
         gasp_pkg::MV_ROW_DEC: begin
            par_ok = t_r_ff < gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS - 1);
            par_r  = t_r_ff + gasp_pkg::ROW_W'(1);
         end
         gasp_pkg::MV_COL_INC: begin
            par_ok = t_c_ff != '0;
            par_c  = t_c_ff - gasp_pkg::COL_W'(1);
         end
         gasp_pkg::MV_ROW_INC: begin
            par_ok = t_r_ff != '0;
            par_r  = t_r_ff - gasp_pkg::ROW_W'(1);
         end
      endcase
   end

   // Search sequencer.
   always_comb begin
      state_in      = state_ff;
      sr_in         = sr_ff;
      sc_in         = sc_ff;
      gr_in         = gr_ff;
      gc_in         = gc_ff;
      idx_in        = idx_ff;
      scan_r_in     = scan_r_ff;
      scan_c_in     = scan_c_ff;
      pv_in         = pv_ff;
      pr_in         = pr_ff;
      pc_in         = pc_ff;
      best_found_in = best_found_ff;
      best_est_in   = best_est_ff;
      best_cost_in  = best_cost_ff;
      best_r_in     = best_r_ff;
      best_c_in     = best_c_ff;
      n_in          = n_ff;
      nb_dir_in     = nb_dir_ff;
      nb_r_in       = nb_r_ff;
      nb_c_in       = nb_c_ff;
      nb_ok_in      = nb_ok_ff;
      t_len_in      = t_len_ff;
      k_in          = k_ff;
      t_r_in        = t_r_ff;
      t_c_in        = t_c_ff;
      e_idx_in      = e_idx_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      wcnt_in       = wcnt_ff;
      word_in       = word_ff;
      rd_addr       = nb_idx;
      flag_we       = 1'b0;
      flag_wa       = nb_idx;
      flag_wd       = gasp_pkg::FLAGS_NONE;
      data_we       = 1'b0;
      data_wa       = nb_idx;
      data_wd       = '{cost: g, est: f, dir: nb_dir_ff};
      tb_we         = 1'b0;
      tb_wa         = k_ff;
      tb_wd         = data_rd_ff.dir;
      sq_start      = 1'b0;
      rsp           = '0;

      // Minimum tracking on the data returned by the scan reads.
      if ((state_ff == S_SCAN || state_ff == S_SCANW) && pv_ff
          && flag_rd_ff[gasp_pkg::FLAG_DISC_BIT] && !flag_rd_ff[gasp_pkg::FLAG_CLOSED_BIT]
          && (!best_found_ff || data_rd_ff.est < best_est_ff)) begin
         best_found_in = 1'b1;
         best_est_in   = data_rd_ff.est;
         best_cost_in  = data_rd_ff.cost;
         best_r_in     = pr_ff;
         best_c_in     = pc_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.search) begin
               sr_in = req.start_row;
               sc_in = req.start_col;
               gr_in = req.goal_row;
               gc_in = req.goal_col;
               idx_in = '0;
               if (req.start_row >= gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS)
                   || req.goal_row >= gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS)
                   || req.start_col >= gasp_pkg::COL_W'(gasp_pkg::GRID_COLS)
                   || req.goal_col >= gasp_pkg::COL_W'(gasp_pkg::GRID_COLS)
                   || (req.start_row == req.goal_row && req.start_col == req.goal_col)) begin
                  state_in = S_FAIL;
               end else begin
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            // Clearing pass over the flag memory.
            flag_we = 1'b1;
            flag_wa = idx_ff;
            flag_wd = gasp_pkg::FLAGS_NONE;
            if (idx_ff == gasp_pkg::CELL_W'(gasp_pkg::CELLS - 1)) begin
               state_in = S_INIT;
            end else begin
               idx_in = idx_ff + gasp_pkg::CELL_W'(1);
            end
         end
         S_INIT: begin
            flag_we  = 1'b1;
            flag_wa  = start_idx;
            flag_wd  = gasp_pkg::FLAGS_OPEN;
            data_we  = 1'b1;
            data_wa  = start_idx;
            data_wd  = '{cost: '0, est: '0, dir: gasp_pkg::MV_COL_DEC};
            idx_in        = '0;
            scan_r_in     = '0;
            scan_c_in     = '0;
            pv_in         = 1'b0;
            best_found_in = 1'b0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            rd_addr = idx_ff;
            pv_in   = 1'b1;
            pr_in   = scan_r_ff;
            pc_in   = scan_c_ff;
            if (idx_ff == gasp_pkg::CELL_W'(gasp_pkg::CELLS - 1)) begin
               state_in = S_SCANW;
            end else begin
               idx_in = idx_ff + gasp_pkg::CELL_W'(1);
               if (scan_c_ff == gasp_pkg::COL_W'(gasp_pkg::GRID_COLS - 1)) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + gasp_pkg::ROW_W'(1);
               end else begin
                  scan_c_in = scan_c_ff + gasp_pkg::COL_W'(1);
               end
            end
         end
         S_SCANW: begin
            pv_in    = 1'b0;
            state_in = S_POP;
         end
         S_POP: begin
            if (!best_found_ff) begin
               state_in = S_FAIL;
            end else begin
               flag_we  = 1'b1;
               flag_wa  = gasp_pkg::cell_index(best_r_ff, best_c_ff);
               flag_wd  = gasp_pkg::FLAGS_CLOSED;
               n_in     = 2'd0;
               state_in = S_NB;
            end
         end
         S_NB: begin
            // Neighbor coordinates; an off-grid neighbor keeps the current cell.
            nb_dir_in = gasp_pkg::SCAN_ORDER[n_ff];
            nb_r_in   = best_r_ff;
            nb_c_in   = best_c_ff;
            nb_ok_in  = 1'b0;
            unique case (gasp_pkg::SCAN_ORDER[n_ff])
               gasp_pkg::MV_COL_DEC: begin
                  nb_ok_in = best_c_ff != '0;
                  if (best_c_ff != '0) nb_c_in = best_c_ff - gasp_pkg::COL_W'(1);
               end
               gasp_pkg::MV_ROW_DEC: begin
                  nb_ok_in = best_r_ff != '0;
                  if (best_r_ff != '0) nb_r_in = best_r_ff - gasp_pkg::ROW_W'(1);
               end
               gasp_pkg::MV_COL_INC: begin
                  nb_ok_in = best_c_ff < gasp_pkg::COL_W'(gasp_pkg::GRID_COLS - 1);
                  if (best_c_ff < gasp_pkg::COL_W'(gasp_pkg::GRID_COLS - 1)) begin
                     nb_c_in = best_c_ff + gasp_pkg::COL_W'(1);
                  end
               end
               gasp_pkg::MV_ROW_INC: begin
                  nb_ok_in = best_r_ff < gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS - 1);
                  if (best_r_ff < gasp_pkg::ROW_W'(gasp_pkg::GRID_ROWS - 1)) begin
                     nb_r_in = best_r_ff + gasp_pkg::ROW_W'(1);
                  end
               end
            endcase
            state_in = S_NBADR;
         end
         S_NBADR: begin
            if (!nb_ok_ff) begin
               if (n_ff == 2'd3) begin
                  idx_in = '0; scan_r_in = '0; scan_c_in = '0;
                  pv_in = 1'b0; best_found_in = 1'b0; state_in = S_SCAN;
               end else begin
                  n_in = n_ff + 2'd1; state_in = S_NB;
               end
            end else if (nb_r_ff == gr_ff && nb_c_ff == gc_ff) begin
               // Goal next to the popped cell: start the trace back.
               tb_we    = 1'b1;
               tb_wa    = '0;
               tb_wd    = nb_dir_ff;
               t_len_in = (len_full > (gasp_pkg::COST_W + 1)'(gasp_pkg::CELLS))
                          ? gasp_pkg::LEN_W'(gasp_pkg::CELLS)
                          : gasp_pkg::LEN_W'(len_full);
               k_in     = gasp_pkg::TB_W'(1);
               t_r_in   = best_r_ff;
               t_c_in   = best_c_ff;
               state_in = S_TLOOP;
            end else begin
               state_in = S_NBCHK;
            end
         end
         S_NBCHK: begin
            if (!flag_rd_ff[gasp_pkg::FLAG_CLOSED_BIT] && open_bit) begin
               sq_start = 1'b1;
               state_in = S_SQRT;
            end else if (n_ff == 2'd3) begin
               idx_in = '0; scan_r_in = '0; scan_c_in = '0;
               pv_in = 1'b0; best_found_in = 1'b0; state_in = S_SCAN;
            end else begin
               n_in = n_ff + 2'd1; state_in = S_NB;
            end
         end
         S_SQRT: begin
            if (sq_done) state_in = S_NBUPD;
         end
         S_NBUPD: begin
            if (!flag_rd_ff[gasp_pkg::FLAG_DISC_BIT] || data_rd_ff.est > f) begin
               flag_we = 1'b1;
               flag_wd = gasp_pkg::FLAGS_OPEN;
               data_we = 1'b1;
            end
            if (n_ff == 2'd3) begin
               idx_in = '0; scan_r_in = '0; scan_c_in = '0;
               pv_in = 1'b0; best_found_in = 1'b0; state_in = S_SCAN;
            end else begin
               n_in = n_ff + 2'd1; state_in = S_NB;
            end
         end
         S_TLOOP: begin
            rd_addr = gasp_pkg::cell_index(t_r_ff, t_c_ff);
            if (gasp_pkg::LEN_W'(k_ff) >= t_len_ff || (t_r_ff == sr_ff && t_c_ff == sc_ff)) begin
               total_in = gasp_pkg::LEN_W'(k_ff);
               rem_in   = gasp_pkg::LEN_W'(k_ff);
               e_idx_in = '0;
               state_in = S_EWORD;
            end else begin
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            // Record the move into this cell and step to its parent.
            tb_we = 1'b1;
            if (!par_ok) begin
               total_in = gasp_pkg::LEN_W'(k_ff);
               rem_in   = gasp_pkg::LEN_W'(k_ff);
               e_idx_in = '0;
               state_in = S_EWORD;
            end else begin
               t_r_in   = par_r;
               t_c_in   = par_c;
               k_in     = k_ff + gasp_pkg::TB_W'(1);
               state_in = S_TLOOP;
            end
         end
         S_EWORD: begin
            word_in  = '0;
            pos_in   = '0;
            wcnt_in  = (rem_ff > gasp_pkg::LEN_W'(gasp_pkg::WORD_MOVES))
                       ? gasp_pkg::CNT_W'(gasp_pkg::WORD_MOVES)
                       : gasp_pkg::CNT_W'(rem_ff);
            state_in = S_ERD;
         end
         S_ERD: begin
            state_in = (pos_ff == wcnt_ff) ? S_EOUT : S_ERX;
         end
         S_ERX: begin
            word_in[{pos_ff[4:0], 1'b0} +: 2] = tb_rd_ff;
            pos_in   = pos_ff + gasp_pkg::CNT_W'(1);
            e_idx_in = e_idx_ff + gasp_pkg::TB_W'(1);
            state_in = S_ERD;
         end
         S_EOUT: begin
            rsp.valid         = 1'b1;
            rsp.found         = 1'b1;
            rsp.path_length   = total_ff;
            rsp.moves_word    = word_ff;
            rsp.moves_in_word = wcnt_ff;
            rsp.last          = rem_ff == gasp_pkg::LEN_W'(wcnt_ff);
            if (rsp_take) begin
               rem_in   = rem_ff - gasp_pkg::LEN_W'(wcnt_ff);
               state_in = (rem_ff == gasp_pkg::LEN_W'(wcnt_ff)) ? S_IDLE : S_EWORD;
            end
         end
         S_FAIL: begin
            rsp.valid = 1'b1;
            rsp.last  = 1'b1;
            if (rsp_take) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = state_ff != S_IDLE;

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (row_load) row_valid_ff[req.row_index] <= 1'b1;
      end
      sr_ff         <= sr_in;
      sc_ff         <= sc_in;
      gr_ff         <= gr_in;
      gc_ff         <= gc_in;
      idx_ff        <= idx_in;
      scan_r_ff     <= scan_r_in;
      scan_c_ff     <= scan_c_in;
      pv_ff         <= pv_in;
      pr_ff         <= pr_in;
      pc_ff         <= pc_in;
      best_found_ff <= best_found_in;
      best_est_ff   <= best_est_in;
      best_cost_ff  <= best_cost_in;
      best_r_ff     <= best_r_in;
      best_c_ff     <= best_c_in;
      n_ff          <= n_in;
      nb_dir_ff     <= nb_dir_in;
      nb_r_ff       <= nb_r_in;
      nb_c_ff       <= nb_c_in;
      nb_ok_ff      <= nb_ok_in;
      t_len_ff      <= t_len_in;
      k_ff          <= k_in;
      t_r_ff        <= t_r_in;
      t_c_ff        <= t_c_in;
      e_idx_ff      <= e_idx_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      wcnt_ff       <= wcnt_in;
      word_ff       <= word_in;
   end

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (data_we) data_mem[data_wa] <= data_wd;
      if (row_load) open_mem[req.row_index] <= req.row_bits;
      if (tb_we) tb_mem[tb_wa] <= tb_wd;
      flag_rd_ff <= flag_mem[rd_addr];
      data_rd_ff <= data_mem[rd_addr];
      open_rd_ff <= open_mem[nb_r_ff];
      tb_rd_ff   <= tb_mem[e_idx_ff];
   end

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// Grid A* path search testbench
// Loads grid rows and runs searches through the request channel. A built-in
// A* predictor computes the move words each search should return, and every
// result transfer is compared field by field with the oldest one pending.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic                        found;
      logic [gasp_pkg::LEN_W-1:0]  path_length;
      logic [gasp_pkg::WORD_W-1:0] moves_word;
      logic [gasp_pkg::CNT_W-1:0]  moves_in_word;
      logic                        last;
   } path_word_type;

   localparam int CYCLE_LIMIT = 6000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_func = gasp_pkg::FUNC_LOAD;
   logic [gasp_pkg::ROW_W-1:0]     req_row_index = '0;
   logic [gasp_pkg::ROWBITS_W-1:0] req_row_open_bits = '0;
   logic [gasp_pkg::ROW_W-1:0]     req_start_row = '0;
   logic [gasp_pkg::COL_W-1:0]     req_start_col = '0;
   logic [gasp_pkg::ROW_W-1:0]     req_goal_row = '0;
   logic [gasp_pkg::COL_W-1:0]     req_goal_col = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_found;
   logic [gasp_pkg::LEN_W-1:0]     rsp_path_length;
   logic [gasp_pkg::WORD_W-1:0]    rsp_moves_word;
   logic [gasp_pkg::CNT_W-1:0]     rsp_moves_in_word;
   logic                           rsp_last;

   // Predictor state.
   bit                   grid_open [gasp_pkg::CELLS];
   bit                   cell_closed [gasp_pkg::CELLS];
   bit                   cell_seen [gasp_pkg::CELLS];
   int unsigned          cell_cost [gasp_pkg::CELLS];
   longint unsigned      cell_est [gasp_pkg::CELLS];
   logic [1:0]           cell_dir [gasp_pkg::CELLS];
   logic [1:0]           trail [gasp_pkg::CELLS + 1];
   path_word_type        pending_words [$];

   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   sender_idle = 0;
   int                   receiver_idle = 0;

   grid_astar_path_search dut (.*);

   always #5 clock = ~clock;

   // Cycle counter with a hard stop.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int row_step(input logic [1:0] mv);
      unique case (mv)
         gasp_pkg::MV_ROW_DEC: return -1;
         gasp_pkg::MV_ROW_INC: return 1;
         default:              return 0;
      endcase
   endfunction

   function automatic int col_step(input logic [1:0] mv);
      unique case (mv)
         gasp_pkg::MV_COL_DEC: return -1;
         gasp_pkg::MV_COL_INC: return 1;
         default:              return 0;
      endcase
   endfunction

   // Integer square root, rounded down.
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned goal_distance(input int r, input int c,
                                                     input int gr, input int gc);
      longint unsigned dr = (r > gr) ? r - gr : gr - r;
      longint unsigned dc = (c > gc) ? c - gc : gc - c;
      return floor_sqrt((dr * dr + dc * dc) << (2 * gasp_pkg::FRAC_BITS));
   endfunction

   task automatic queue_failure();
      path_word_type w;
      w.found = 1'b0; w.path_length = '0; w.moves_word = '0;
      w.moves_in_word = '0; w.last = 1'b1;
      pending_words = {pending_words, w};
   endtask

   // Walk parents back from the cell beside the goal and queue the move words.
   task automatic queue_path(input int cur, input logic [1:0] first_mv, input int origin);
      int unsigned   len;
      int unsigned   k;
      int unsigned   nwords;
      int unsigned   cnt;
      int            walk_idx;
      int            r;
      int            c;
      logic [1:0]    d;
      path_word_type w;
      len = cell_cost[cur] + 1;
      if (len > gasp_pkg::CELLS) len = gasp_pkg::CELLS;
      trail[0] = first_mv;
      walk_idx = cur;
      k = 1;
      while (k < len && walk_idx != origin) begin
         d = cell_dir[walk_idx];
         trail[k] = d;
         r = walk_idx / gasp_pkg::GRID_COLS - row_step(d);
         c = walk_idx % gasp_pkg::GRID_COLS - col_step(d);
         if (r < 0 || r >= gasp_pkg::GRID_ROWS || c < 0 || c >= gasp_pkg::GRID_COLS) break;
         walk_idx = r * gasp_pkg::GRID_COLS + c;
         k++;
      end
      nwords = (k + 31) / 32;
      for (int unsigned wi = 0; wi < nwords; wi++) begin
         cnt = k - wi * 32;
         if (cnt > 32) cnt = 32;
         w.moves_word = '0;
         for (int unsigned i = 0; i < cnt; i++)
            w.moves_word[2*i +: 2] = trail[wi * 32 + i];
         w.found = 1'b1;
         w.path_length = gasp_pkg::LEN_W'(k);
         w.moves_in_word = gasp_pkg::CNT_W'(cnt);
         w.last = (wi + 1 == nwords);
         pending_words = {pending_words, w};
      end
   endtask

   // A* over the predicted grid; queues the expected result words.
   task automatic predict_search(input int sr, input int sc, input int gr, input int gc);
      int              origin;
      int              cur;
      int              r;
      int              c;
      int              nr;
      int              nc;
      int              ni;
      int unsigned     g;
      longint unsigned f;
      logic [1:0]      d;
      if (sr >= gasp_pkg::GRID_ROWS || sc >= gasp_pkg::GRID_COLS ||
          gr >= gasp_pkg::GRID_ROWS || gc >= gasp_pkg::GRID_COLS ||
          (sr == gr && sc == gc)) begin
         queue_failure();
         return;
      end
      for (int i = 0; i < gasp_pkg::CELLS; i++) begin
         cell_closed[i] = 0;
         cell_seen[i] = 0;
      end
      origin = sr * gasp_pkg::GRID_COLS + sc;
      cell_seen[origin] = 1;
      cell_cost[origin] = 0;
      cell_est[origin] = 0;
      cell_dir[origin] = gasp_pkg::MV_COL_DEC;
      for (int step = 0; step < gasp_pkg::CELLS; step++) begin
         cur = -1;
         for (int i = 0; i < gasp_pkg::CELLS; i++)
            if (cell_seen[i] && !cell_closed[i] && (cur < 0 || cell_est[i] < cell_est[cur]))
               cur = i;
         if (cur < 0) break;
         cell_closed[cur] = 1;
         r = cur / gasp_pkg::GRID_COLS;
         c = cur % gasp_pkg::GRID_COLS;
         for (int n = 0; n < 4; n++) begin
            d = gasp_pkg::SCAN_ORDER[n];
            nr = r + row_step(d);
            nc = c + col_step(d);
            if (nr < 0 || nr >= gasp_pkg::GRID_ROWS || nc < 0 || nc >= gasp_pkg::GRID_COLS)
               continue;
            if (nr == gr && nc == gc) begin
               queue_path(cur, d, origin);
               return;
            end
            ni = nr * gasp_pkg::GRID_COLS + nc;
            if (!cell_closed[ni] && grid_open[ni]) begin
               g = (cell_cost[cur] + 1) & 11'h7FF;
               f = (longint'(g) << gasp_pkg::FRAC_BITS) + goal_distance(nr, nc, gr, gc);
               if (!cell_seen[ni] || cell_est[ni] > f) begin
                  cell_seen[ni] = 1;
                  cell_cost[ni] = g;
                  cell_est[ni] = f;
                  cell_dir[ni] = d;
               end
            end
         end
      end
      queue_failure();
   endtask

   // Sends one item, waits for its transfer, then updates the prediction.
   task automatic send_item(input logic func, input int row, input logic [32:0] bits,
                            input int sr, input int sc, input int gr, input int gc);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_row_index <= gasp_pkg::ROW_W'(row);
      req_row_open_bits <= bits;
      req_start_row <= gasp_pkg::ROW_W'(sr);
      req_start_col <= gasp_pkg::COL_W'(sc);
      req_goal_row <= gasp_pkg::ROW_W'(gr);
      req_goal_col <= gasp_pkg::COL_W'(gc);
      do @(posedge clock); while (req_stall);
      if (func == gasp_pkg::FUNC_SEARCH) begin
         predict_search(sr, sc, gr, gc);
      end else if (row < gasp_pkg::GRID_ROWS) begin
         for (int c = 0; c < gasp_pkg::GRID_COLS; c++)
            grid_open[row * gasp_pkg::GRID_COLS + c] =
               (c < gasp_pkg::ROWBITS_W) ? bits[c] : 1'b0;
      end
   endtask

   task automatic load_row(input int row, input logic [32:0] bits);
      send_item(gasp_pkg::FUNC_LOAD, row, bits, $urandom_range(63), $urandom_range(63),
                $urandom_range(63), $urandom_range(63));
   endtask

   task automatic search(input int sr, input int sc, input int gr, input int gc);
      send_item(gasp_pkg::FUNC_SEARCH, $urandom_range(63), 33'({$urandom, $urandom}),
                sr, sc, gr, gc);
   endtask

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      error_count++;
   endtask

   // Receiver: random stall and the check of every result transfer.
   always @(posedge clock) begin
      path_word_type w;
      rsp_stall <= ($urandom_range(99) < receiver_idle);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result", rsp_moves_word, 0);
         end else begin
            w = pending_words.pop_front();
            if (rsp_found !== w.found) report_mismatch("found", rsp_found, w.found);
            if (rsp_path_length !== w.path_length)
               report_mismatch("path_length", rsp_path_length, w.path_length);
            if (rsp_moves_word !== w.moves_word)
               report_mismatch("moves_word", rsp_moves_word, w.moves_word);
            if (rsp_moves_in_word !== w.moves_in_word)
               report_mismatch("moves_in_word", rsp_moves_in_word, w.moves_in_word);
            if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
         end
      end
   end

   // Loads to rows outside the grid and searches that fail on their coordinates.
   task automatic test_trivial_cases();
      load_row(40, {33{1'b1}});
      load_row(63, 33'({$urandom, $urandom}));
      search(5, 5, 5, 5);
      search(33, 0, 0, 0);
      search(0, 0, 0, 63);
   endtask

   // Full bottom row: exactly one full move word each way.
   task automatic test_edge_corridor();
      load_row(32, {33{1'b1}});
      search(32, 0, 32, 32);
      search(32, 32, 32, 0);
   endtask

   // An L-shaped corridor gives long paths, two of them spanning two move words.
   task automatic test_long_path();
      for (int r = 20; r < 32; r++) load_row(r, 33'h1_0000_0000);
      search(32, 0, 20, 32);
      search(32, 0, 19, 32);
      search(20, 32, 32, 31);
   endtask

   // Blocked start still expands; an isolated start finds nothing.
   task automatic test_blocked_cells();
      search(0, 0, 0, 1);
      search(0, 0, 5, 5);
   endtask

   // Random maps confined to small windows so each search stays short.
   task automatic test_random_windows(input int windows);
      int rb;
      int cb;
      int sr;
      int sc;
      int gr;
      int gc;
      for (int i = 0; i < windows; i++) begin
         rb = $urandom_range(29);
         cb = $urandom_range(27);
         for (int r = 0; r < 4; r++)
            load_row(rb + r, 33'($urandom_range(63) | $urandom_range(63)) << cb);
         load_row($urandom_range(33, 63), 33'({$urandom, $urandom}));
         for (int s = 0; s < 3; s++) begin
            if ($urandom_range(3) == 0) begin
               search($urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(63));
            end else begin
               sr = rb + $urandom_range(3); sc = cb + $urandom_range(5);
               gr = rb + $urandom_range(3); gc = cb + $urandom_range(5);
               search(sr, sc, gr, gc);
            end
         end
         for (int r = 0; r < 4; r++) load_row(rb + r, '0);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      sender_idle = 16;
      receiver_idle = 61;
      test_trivial_cases();
      test_edge_corridor();
      test_long_path();
      test_blocked_cells();
      for (int r = 20; r <= 32; r++) load_row(r, '0);

      sender_idle = 61;
      receiver_idle = 16;
      test_random_windows(3);

      sender_idle = 0;
      receiver_idle = 0;
      test_random_windows(3);

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/gasp_pkg.sv
src/gasp_isqrt.sv
src/gasp_core.sv
src/grid_astar_path_search.sv
tb/testbench.sv
